FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is held off while reset is high.
`define ASSERT_RST(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: sv/slad_pkg.sv
`default_nettype none

package slad_pkg;

  // Samples per block are a power of two, so the mean is a bit slice of the sum.
  localparam int AVG_LOG2    = 3;
  localparam int AVG_SAMPLES = 1 << AVG_LOG2;

  localparam int DATA_W  = 16;
  localparam int SUM_W   = DATA_W + AVG_LOG2;
  localparam int FILL_W  = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
  localparam int RUN_W   = DATA_W + 1;
  localparam int DIV_CNT_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD      = 2'd0,
    REG_THRESHOLD_TIME = 2'd1,
    REG_ADC_PERIOD     = 2'd2
  } reg_index_t;

  // One block mean moving between the front, the queue and the back.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] mean;
  } mean_word_t;

endpackage

`default_nettype wire

FILE: sv/slad_div.sv
`default_nettype none

`include "assert_macros.svh"

module slad_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [slad_pkg::DATA_W-1:0] dividend,
  input  logic [slad_pkg::DATA_W-1:0] divisor,
  output logic                        busy,
  output logic [slad_pkg::DATA_W-1:0] limit
);
  import slad_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      trial;
  logic                 ge;

  // Restoring division, one quotient bit a cycle. A zero divisor gives all ones.
  assign shifted = {rem, quo[DATA_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      limit <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == {DIV_CNT_W{1'b1}}) begin
        busy  <= 1'b0;
        limit <= {quo[DATA_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DATA_W-2:0], ge};
      rem <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
    end
  end

  `ASSERT_RST(a_start_busy, clk, rst, start |=> busy)

endmodule

`default_nettype wire

FILE: sv/slad_front.sv
`default_nettype none

module slad_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [slad_pkg::DATA_W-1:0] sample,
  output slad_pkg::mean_word_t        push_word
);
  import slad_pkg::*;

  logic [SUM_W-1:0]  block_sum;
  logic [FILL_W-1:0] block_fill;
  logic [SUM_W-1:0]  sum_next;
  logic              last;

  assign sum_next = block_sum + SUM_W'(sample);
  assign last     = block_fill == FILL_W'(AVG_SAMPLES - 1);

  assign push_word.valid = take && last;
  assign push_word.mean  = sum_next[AVG_LOG2 +: DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum  <= '0;
      block_fill <= '0;
    end else if (take) begin
      block_sum  <= last ? '0 : sum_next;
      block_fill <= last ? '0 : block_fill + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/slad_queue.sv
`default_nettype none

`include "assert_macros.svh"

module slad_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  slad_pkg::mean_word_t push_word,
  input  logic                 pop,
  output slad_pkg::mean_word_t head,
  output logic                 full
);
  import slad_pkg::*;

  logic [DATA_W-1:0] entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full       = count == 2'd2;
  assign head.valid = count != 2'd0;
  assign head.mean  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_word.valid) begin
      entries[wr_ptr] <= push_word.mean;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push_word.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_word.valid} - {1'b0, pop};
    end
  end

  `ASSERT_RST(a_no_overflow, clk, rst, !(push_word.valid && !pop && full))
  `ASSERT_RST(a_no_underflow, clk, rst, pop |-> head.valid)

endmodule

`default_nettype wire

FILE: sv/slad_back.sv
`default_nettype none

`include "assert_macros.svh"

module slad_back (
  input  logic                        clk,
  input  logic                        rst,
  input  slad_pkg::mean_word_t        head,
  output logic                        pop,
  input  logic [slad_pkg::DATA_W-1:0] threshold,
  input  logic [slad_pkg::DATA_W-1:0] limit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [slad_pkg::DATA_W-1:0] average,
  output logic [slad_pkg::DATA_W-1:0] detection_count,
  output logic                        detected
);
  import slad_pkg::*;

  logic [RUN_W-1:0]  run_length;
  logic [DATA_W-1:0] detections;
  logic [RUN_W-1:0]  run_inc;
  logic              hit;

  assign pop = head.valid && (!out_valid || out_ready);

  assign run_inc = (head.mean > threshold) ? run_length + 1'b1 : '0;
  assign hit     = run_inc > {1'b0, limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= '0;
      detections <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        run_length <= hit ? '0 : run_inc;
        detections <= hit ? detections + 1'b1 : detections;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      average         <= head.mean;
      detection_count <= hit ? detections + 1'b1 : detections;
      detected        <= hit;
    end
  end

  `ASSERT_RST(a_hit_clears_run, clk, rst, (pop && hit) |=> (run_length == '0 && detected))

endmodule

`default_nettype wire

FILE: sv/sound_level_duration_detector_top.sv
// Sound level duration detector.
// The sample channel (in_valid, in_ready, sample) takes one raw ADC word per
// accept. Every block of eight words yields one result word on the output
// channel (out_valid, out_ready, average, detection_count, detected); the
// other words yield nothing.
// Throughput is one sample a cycle while the divider is idle and the two-entry mean queue has room.
// A block's mean is registered in the queue and then in the output register before its result can be taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready. A write to threshold_time or adc_period starts a serial
// divider for the duration limit; it works out the quotient bit by bit,
// and in_ready stays low meanwhile.
// Reset clears all counters and loads threshold 0, threshold_time 0 and
// adc_period 1, so the duration limit starts at zero.
// When the receiver stalls, the result stays in the output register, the
// queue fills, and then in_ready drops until a result is taken.
`default_nettype none

module sound_level_duration_detector_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [slad_pkg::DATA_W-1:0]    sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [slad_pkg::DATA_W-1:0]    average,
  output logic [slad_pkg::DATA_W-1:0]    detection_count,
  output logic                           detected,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slad_pkg::DATA_W-1:0]    cfg_data
);
  import slad_pkg::*;

  logic [DATA_W-1:0] threshold;
  logic [DATA_W-1:0] threshold_time;
  logic [DATA_W-1:0] adc_period;
  logic              div_start;
  logic              div_busy;
  logic [DATA_W-1:0] limit;
  logic              q_full;
  logic              pop;
  logic              cfg_take;
  mean_word_t        push_word;
  mean_word_t        head;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_ready  = !div_start && !div_busy && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      threshold_time <= '0;
      adc_period     <= DATA_W'(1);
      div_start      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_take) begin
        case (cfg_index)
          REG_THRESHOLD: begin
            threshold <= cfg_data;
          end
          REG_THRESHOLD_TIME: begin
            threshold_time <= cfg_data;
            div_start      <= 1'b1;
          end
          REG_ADC_PERIOD: begin
            adc_period <= cfg_data;
            div_start  <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  slad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (threshold_time),
    .divisor  (adc_period),
    .busy     (div_busy),
    .limit    (limit)
  );

  slad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (in_valid && in_ready),
    .sample    (sample),
    .push_word (push_word)
  );

  slad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .full      (q_full)
  );

  slad_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .threshold       (threshold),
    .limit           (limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .average         (average),
    .detection_count (detection_count),
    .detected        (detected)
  );

endmodule

`default_nettype wire

FILE: tb/slad_checker.sv
`default_nettype none

module slad_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [slad_pkg::DATA_W-1:0]    sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [slad_pkg::DATA_W-1:0]    average,
  input  logic [slad_pkg::DATA_W-1:0]    detection_count,
  input  logic                           detected,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [slad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slad_pkg::DATA_W-1:0]    cfg_data,
  output int                             pending,
  output int                             mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import slad_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] count;
    logic              hit;
  } level_result_t;

  level_result_t     expected_levels[$];

  logic [DATA_W-1:0] thr_reg;
  logic [DATA_W-1:0] dur_reg;
  logic [DATA_W-1:0] period_reg;

  logic [SUM_W-1:0]  acc_sum;
  int                acc_fill;
  logic [RUN_W-1:0]  loud_run;
  logic [DATA_W-1:0] det_total;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  // A zero period makes the divider answer all ones.
  function automatic logic [DATA_W-1:0] duration_limit();
    if (period_reg == '0) begin
      return '1;
    end
    return dur_reg / period_reg;
  endfunction

  task automatic predict_block_level(input logic [DATA_W-1:0] s);
    level_result_t     r;
    logic [SUM_W-1:0]  total;
    int                quotient;
    total = acc_sum + s;
    if (acc_fill + 1 < AVG_SAMPLES) begin
      acc_sum  = total;
      acc_fill = acc_fill + 1;
      return;
    end
    quotient = total / AVG_SAMPLES;
    r.level  = quotient[DATA_W-1:0];
    acc_sum  = '0;
    acc_fill = 0;
    if (r.level > thr_reg) begin
      loud_run = loud_run + 1'b1;
    end else begin
      loud_run = '0;
    end
    r.hit = 1'b0;
    if (loud_run > duration_limit()) begin
      det_total = det_total + 1'b1;
      loud_run  = '0;
      r.hit     = 1'b1;
    end
    r.count = det_total;
    expected_levels.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    level_result_t want;
    level_result_t got;
    if (rst) begin
      thr_reg    = '0;
      dur_reg    = '0;
      period_reg = 16'd1;
      acc_sum    = '0;
      acc_fill   = 0;
      loud_run   = '0;
      det_total  = '0;
      expected_levels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:      thr_reg    = cfg_data;
          REG_THRESHOLD_TIME: dur_reg    = cfg_data;
          REG_ADC_PERIOD:     period_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_block_level(sample);
      end
      if (out_valid && out_ready) begin
        got.level = average;
        got.count = detection_count;
        got.hit   = detected;
        if (expected_levels.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result word: average %h count %h detected %b",
                     $time, got.level, got.count, got.hit);
          end
        end else begin
          want = expected_levels.pop_front();
          if (want != got) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected average %h count %h detected %b",
                       $time, want.level, want.count, want.hit);
              $display("%0t:                  got average %h count %h detected %b",
                       $time, got.level, got.count, got.hit);
            end
          end
        end
      end
    end
    pending <= expected_levels.size();
  end

endmodule

`default_nettype wire

FILE: tb/sound_level_duration_detector_top_tb.sv
`default_nettype none

module sound_level_duration_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slad_pkg::*;

  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    average;
  logic [DATA_W-1:0]    detection_count;
  logic                 detected;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int                   pending;
  int                   mismatches;
  int                   cycle_count = 0;
  int                   hold_seq = 0;
  logic [DATA_W-1:0]    sample_queue[$];

  sound_level_duration_detector_top DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .average         (average),
    .detection_count (detection_count),
    .detected        (detected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  slad_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .average         (average),
    .detection_count (detection_count),
    .detected        (detected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .mismatches      (mismatches)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sound_level_duration_detector_top_tb: FAIL");
      $finish;
    end
  end

  // Result side: random stretches of readiness, plus a long hold-off on request.
  initial begin : result_side
    int mode;
    int len;
    int hold_served;
    hold_served = 0;
    out_ready   = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_seq != hold_served) begin
        hold_served = hold_seq;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic int burst_len();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(24, 64);
    end
    return $urandom_range(1, 12);
  endfunction

  task automatic send_queued();
    int burst;
    burst = burst_len();
    while (sample_queue.size() != 0) begin
      in_valid <= 1'b1;
      sample   <= sample_queue.pop_front();
      do @(posedge clk); while (!in_ready);
      burst = burst - 1;
      if (burst == 0 || sample_queue.size() == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst = burst_len();
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] dur,
                            input logic [DATA_W-1:0] per);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_THRESHOLD_TIME, dur);
    write_reg(REG_ADC_PERIOD, per);
    write_reg(REG_SPARE, DATA_W'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected word has come, then idles before returning; the words
  // of a partial block stay summed in the front end, which yields nothing for them.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One block of eight words, all of one kind: mostly loud or quiet against the
  // threshold so that runs form, some at or just above it and some pure noise.
  task automatic queue_block(input logic [DATA_W-1:0] thr);
    int kind;
    int lo;
    lo   = thr + 1;
    kind = $urandom_range(0, 15);
    repeat (AVG_SAMPLES) begin
      if (kind == 0 || (thr == 16'hFFFF && kind >= 2 && kind <= 11)) begin
        sample_queue.push_back(DATA_W'($urandom_range(0, 65535)));
      end else if (kind == 1) begin
        sample_queue.push_back(thr);
      end else if (kind == 2) begin
        sample_queue.push_back(DATA_W'(lo));
      end else if (kind <= 11) begin
        sample_queue.push_back(DATA_W'($urandom_range(lo, 65535)));
      end else begin
        sample_queue.push_back(DATA_W'($urandom_range(0, thr)));
      end
    end
  endtask

  initial begin : stimulus
    int                phase;
    int                blocks;
    logic [DATA_W-1:0] thr;
    logic [DATA_W-1:0] dur;
    logic [DATA_W-1:0] per;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings give a zero duration limit, so any nonzero mean detects.
    repeat (AVG_SAMPLES) sample_queue.push_back(16'hFFFF);
    repeat (AVG_SAMPLES) sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'h0000);
    sample_queue.push_back(16'hFFFF);
    sample_queue.push_back(16'hAAAA);
    sample_queue.push_back(16'h5555);
    sample_queue.push_back(16'h0001);
    sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h7FFF);
    sample_queue.push_back(16'hFFFE);
    send_queued();
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          thr = 16'hFFFF; dur = 16'hFFFF; per = 16'h0000;
        end
        1: begin
          thr = 16'h0000; dur = 16'hFFFF; per = 16'hFFFF;
        end
        2: begin
          thr = 16'h8000; dur = 16'h0003; per = 16'h0001;
        end
        3: begin
          thr = DATA_W'($urandom_range(16'h1000, 16'hF000)); dur = 16'h0000; per = 16'h0000;
        end
        4: begin
          thr = DATA_W'($urandom_range(0, 65535)); dur = 16'd5; per = 16'hFFFF;
        end
        default: begin
          thr = DATA_W'($urandom_range(16'h1000, 16'hF000));
          dur = DATA_W'($urandom_range(0, 40));
          per = DATA_W'($urandom_range(1, 12));
        end
      endcase
      set_config(thr, dur, per);
      blocks = (phase == 3) ? 12 : 6;
      repeat (blocks) queue_block(thr);
      repeat ($urandom_range(0, AVG_SAMPLES - 1)) begin
        sample_queue.push_back(DATA_W'($urandom_range(0, 65535)));
      end
      // The result side stalls for a long time here so the input backs up.
      if (phase == 3) begin
        hold_seq = hold_seq + 1;
      end
      send_queued();
      drain();
    end

    if (mismatches == 0) begin
      $display("sound_level_duration_detector_top_tb: PASS");
    end else begin
      $display("sound_level_duration_detector_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
